@@ sv/sdspi_pkg.sv @@
// types, codes and crc helper shared by the sd spi command engine files
package sdspi_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_RX    = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [6:0] CRC_POLY   = 7'h09;
	localparam logic [7:0] START_BITS = 8'h40;
	localparam logic [7:0] POLL_BYTE  = 8'hff;
	localparam logic [7:0] NO_CRC     = 8'h01;
	localparam logic [5:0] CMD_IF_COND = 6'd8;
	localparam logic [5:0] CMD_READ_OCR = 6'd58;
	localparam logic [15:0] ELAPSED_MAX = 16'hffff;
	localparam logic [2:0] FRAME_TAIL = 3'd6;

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  cmd_index;
		logic [31:0] argument;
		logic        use_crc;
		logic [15:0] timeout_ms;
		logic [7:0]  rx_byte;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [7:0]  r1;
		logic [31:0] resp_data;
		logic        last;
	} rsp_item_t;

	// one byte of crc7, msb first
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
		logic [6:0] c;
		logic       fb;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ b[i];
			c = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

@@ sv/sd_spi_command_engine_core.sv @@
// sd card spi mode command engine: framing, crc7 and r1/r3/r7 response capture
//
// req channel: one transfer per item (start command, byte received, 1 ms tick).
// rsp channel: result transfers; a start gives seven tx bytes (the six frame
// bytes, then a 0xff poll), a received byte gives at most one result, a tick
// gives none. last marks the final result of an item.
// order: an accepted item waits in the input register until the output
// register is free; its first result is then loaded into the output register
// and shows on rsp, where it transfers at the first edge without rsp_stall.
// throughput: one item per cycle while results drain; a start holds the
// output register for seven rsp transfers, so the next item waits in the
// input register until the poll byte goes out. the crc7 is built one frame
// byte per rsp transfer while the frame streams, ready for the sixth byte.
// stall on rsp freezes the output register; when the input register is full
// and the output is busy, req_stall rises; the sender stalls after one item.
// reset: idle phase, no pending results, all counters and held values zero.
module sd_spi_command_engine_core
	import sdspi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	// input register
	req_item_t req_s1;
	logic      valid_s1;

	// engine state
	phase_t      phase_q;
	logic [5:0]  held_cmd_q;
	logic [15:0] held_timeout_q;
	logic [15:0] elapsed_q;
	logic [7:0]  status_q;
	logic [31:0] data_shift_q;
	logic [2:0]  data_count_q;

	// output register and frame streamer
	rsp_item_t   out_s2;
	logic        out_valid_s2;
	logic [2:0]  remain_q;     // results still to follow the one on rsp
	logic [31:0] frame_q;      // argument bytes not yet sent
	logic        use_crc_q;
	logic [6:0]  crc_q;        // crc over the frame bytes already on rsp

	logic take, free, process;

	// result of the item in the input register
	rsp_item_t   res;
	logic        res_valid;
	logic        res_start;
	phase_t      phase_d;
	logic [7:0]  status_d;
	logic [31:0] data_shift_d;
	logic [2:0]  data_count_d;
	logic [15:0] elapsed_d;
	logic [7:0]  first_byte;

	assign take      = out_valid_s2 && !rsp_stall;
	assign free      = !out_valid_s2 || (take && remain_q == 3'd0);
	assign process   = valid_s1 && free;
	assign req_stall = valid_s1 && !free;
	assign rsp_valid = out_valid_s2;
	assign rsp       = out_s2;

	assign first_byte = START_BITS | {2'b00, req_s1.cmd_index};

	always_comb begin
		res          = '0;
		res_valid    = 1'b0;
		res_start    = 1'b0;
		phase_d      = phase_q;
		status_d     = status_q;
		data_shift_d = data_shift_q;
		data_count_d = data_count_q;
		elapsed_d    = elapsed_q;
		case (req_s1.op)
			OP_START: begin
				res_valid    = 1'b1;
				res_start    = 1'b1;
				res.kind     = KIND_TX;
				res.tx_byte  = first_byte;
				phase_d      = PH_WAIT;
				status_d     = '0;
				data_shift_d = '0;
				data_count_d = '0;
				elapsed_d    = '0;
			end
			OP_TICK: begin
				if (phase_q == PH_WAIT && elapsed_q != ELAPSED_MAX) begin
					elapsed_d = elapsed_q + 16'd1;
				end
			end
			OP_RX: begin
				case (phase_q)
					PH_WAIT: begin
						res_valid = 1'b1;
						res.last  = 1'b1;
						if (req_s1.rx_byte[7]) begin
							if (elapsed_q >= held_timeout_q) begin
								phase_d  = PH_IDLE;
								res.kind = KIND_TIMEOUT;
							end else begin
								res.kind    = KIND_TX;
								res.tx_byte = POLL_BYTE;
							end
						end else begin
							status_d = req_s1.rx_byte;
							if (held_cmd_q == CMD_IF_COND || held_cmd_q == CMD_READ_OCR) begin
								// r3/r7: four trailing bytes follow
								phase_d      = PH_DATA;
								data_shift_d = '0;
								data_count_d = '0;
								res.kind     = KIND_TX;
								res.tx_byte  = POLL_BYTE;
							end else begin
								phase_d  = PH_IDLE;
								res.kind = KIND_DONE;
								res.r1   = req_s1.rx_byte;
							end
						end
					end
					PH_DATA: begin
						res_valid    = 1'b1;
						res.last     = 1'b1;
						data_shift_d = {data_shift_q[23:0], req_s1.rx_byte};
						data_count_d = data_count_q + 3'd1;
						if (data_count_q == 3'd3) begin
							phase_d       = PH_IDLE;
							res.kind      = KIND_DONE;
							res.r1        = status_q;
							res.resp_data = data_shift_d;
						end else begin
							res.kind    = KIND_TX;
							res.tx_byte = POLL_BYTE;
						end
					end
					default: begin
						// idle or unused phase code: byte is dropped
					end
				endcase
			end
			default: begin
				// unused op code: no effect
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (process) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			held_cmd_q     <= '0;
			held_timeout_q <= '0;
			elapsed_q      <= '0;
			status_q       <= '0;
			data_shift_q   <= '0;
			data_count_q   <= '0;
		end else if (process) begin
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			status_q     <= status_d;
			data_shift_q <= data_shift_d;
			data_count_q <= data_count_d;
			if (res_start) begin
				held_cmd_q     <= req_s1.cmd_index;
				held_timeout_q <= req_s1.timeout_ms;
			end
		end
	end

	// output register: streams the frame, one byte per rsp transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
			remain_q     <= '0;
		end else begin
			if (process && res_valid) begin
				out_valid_s2 <= 1'b1;
				remain_q     <= res_start ? FRAME_TAIL : 3'd0;
			end else if (take) begin
				if (remain_q != 3'd0) begin
					remain_q <= remain_q - 3'd1;
				end else begin
					out_valid_s2 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && remain_q != 3'd0) begin
			out_s2.last <= (remain_q == 3'd1);
			if (remain_q >= 3'd3) begin
				// argument byte, msb first
				out_s2.tx_byte <= frame_q[31:24];
				frame_q        <= {frame_q[23:0], 8'h00};
				crc_q          <= crc7_byte(crc_q, frame_q[31:24]);
			end else if (remain_q == 3'd2) begin
				out_s2.tx_byte <= use_crc_q ? {crc_q, 1'b1} : NO_CRC;
			end else begin
				out_s2.tx_byte <= POLL_BYTE;
			end
		end
		if (process && res_valid) begin
			out_s2    <= res;
			frame_q   <= req_s1.argument;
			use_crc_q <= req_s1.use_crc;
			crc_q     <= crc7_byte(7'd0, first_byte);
		end
	end

endmodule

@@ sv/sd_spi_command_engine_checker.sv @@
// port level checks for the sd spi command engine, bound into the engine core
module sd_spi_command_engine_checker
	import sdspi_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_item_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	// a stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("req changed while stalled");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// only transmit bytes can be followed by more results of the same item
	a_nontx_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != KIND_TX |-> rsp.last)
		else $error("completion or timeout not marked last");

	// unused fields read as zero
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.kind == KIND_TX) ? (rsp.r1 == 8'h00 && rsp.resp_data == 32'h0)
		                                    : (rsp.tx_byte == 8'h00))
		else $error("unused result field not zero");

	// the frame streams without gaps
	a_frame_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last |=> rsp_valid)
		else $error("gap inside a command frame");

endmodule

bind sd_spi_command_engine_core sd_spi_command_engine_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ dv/sd_spi_command_engine_core_tb.sv @@
// self-checking testbench for the sd card spi command engine core
module sd_spi_command_engine_core_tb;
	import sdspi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// clocking and run budget
	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 480;
	localparam int MAX_GAP      = 19;
	localparam int SETTLE_CYCLES = 6;    // settle time after the last owed result, with margin
	localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int HOLD_AFTER   = 150;   // results seen before the hold-off starts
	localparam int DRAIN_EVERY  = 80;    // useful items between full drains
	localparam int MAX_REPORTS  = 10;
	localparam int unsigned RUN_LIMIT_NS = 20_000_000;

	// the one op code the package leaves unnamed, the block ignores it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// engine phase as the predictor tracks it
	typedef enum logic [1:0] {
		CARD_IDLE,
		CARD_WAIT_R1,
		CARD_COLLECT
	} card_phase_t;

	// one row of the directed table: the transfer and, where obvious, its result
	typedef struct {
		req_item_t item;
		bit        typed;
		rsp_item_t want;
	} drill_row_t;

	// dut connections, every input known from time zero
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// predictor state, a private copy of what the engine holds
	card_phase_t card_phase   = CARD_IDLE;
	logic [5:0]  held_cmd     = '0;
	logic [15:0] held_tmo     = '0;
	logic [15:0] ms_elapsed   = '0;
	logic [7:0]  r1_seen      = '0;
	logic [31:0] trailer      = '0;
	logic [2:0]  trailer_cnt  = '0;

	// results the engine still owes, oldest first
	rsp_item_t card_results_due[$];

	// bookkeeping
	int  failures     = 0;
	int  useful_items = 0;
	int  rsp_seen     = 0;
	int  frames_sent  = 0;
	int  r1_done      = 0;
	int  timeouts     = 0;
	int  rsp_wait     = 0;
	logic hold_rsp    = 1'b0;

	sd_spi_command_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic req_item_t mk_req(logic [1:0] op, logic [5:0] cmd, logic [31:0] arg,
			logic crc, logic [15:0] tmo, logic [7:0] rx);
		req_item_t it;
		it.op         = op;
		it.cmd_index  = cmd;
		it.argument   = arg;
		it.use_crc    = crc;
		it.timeout_ms = tmo;
		it.rx_byte    = rx;
		return it;
	endfunction

	function automatic rsp_item_t mk_rsp(logic [1:0] kind, logic [7:0] tx, logic [7:0] r1,
			logic [31:0] data, logic last);
		rsp_item_t r;
		r.kind      = kind;
		r.tx_byte   = tx;
		r.r1        = r1;
		r.resp_data = data;
		r.last      = last;
		return r;
	endfunction

	// every field random, op included, so that unused fields toggle too
	function automatic req_item_t rand_req();
		return mk_req(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), $urandom,
			1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)));
	endfunction

	// crc7 over the five leading frame bytes, x^7 + x^3 + 1, msb first
	function automatic logic [6:0] frame_crc7(logic [39:0] head);
		logic [6:0] r;
		logic       fb;
		r = '0;
		for (int i = 39; i >= 0; i--) begin
			fb = r[6] ^ head[i];
			r  = {r[5:0], 1'b0} ^ (fb ? CRC_POLY : 7'd0);
		end
		return r;
	endfunction

	// predictor: update the private state for one accepted transfer and
	// queue what the engine must send back for it
	task automatic compute_card_results(input req_item_t it, output int pushed,
			output bit took_effect);
		logic [39:0] head;
		logic [7:0]  crc_byte;
		pushed      = 0;
		took_effect = 1'b0;
		case (it.op)
			OP_START: begin
				// six frame bytes then a poll, a running command is simply dropped
				head     = {START_BITS | {2'b00, it.cmd_index}, it.argument};
				crc_byte = it.use_crc ? {frame_crc7(head), 1'b1} : NO_CRC;
				for (int i = 4; i >= 0; i--) begin
					card_results_due.push_back(mk_rsp(KIND_TX, head[i*8 +: 8], '0, '0, 1'b0));
				end
				card_results_due.push_back(mk_rsp(KIND_TX, crc_byte, '0, '0, 1'b0));
				card_results_due.push_back(mk_rsp(KIND_TX, POLL_BYTE, '0, '0, 1'b1));
				pushed      = 7;
				took_effect = 1'b1;
				frames_sent++;
				card_phase  = CARD_WAIT_R1;
				held_cmd    = it.cmd_index;
				held_tmo    = it.timeout_ms;
				ms_elapsed  = '0;
				r1_seen     = '0;
				trailer     = '0;
				trailer_cnt = '0;
			end
			OP_TICK: begin
				// time only runs while waiting for r1, and it saturates
				if (card_phase == CARD_WAIT_R1) begin
					took_effect = 1'b1;
					if (ms_elapsed != ELAPSED_MAX) begin
						ms_elapsed = ms_elapsed + 16'd1;
					end
				end
			end
			OP_RX: begin
				if (card_phase == CARD_WAIT_R1) begin
					took_effect = 1'b1;
					pushed      = 1;
					if (it.rx_byte[7]) begin
						// card still busy: poll again or give up
						if (ms_elapsed >= held_tmo) begin
							card_phase = CARD_IDLE;
							card_results_due.push_back(mk_rsp(KIND_TIMEOUT, '0, '0, '0, 1'b1));
						end else begin
							card_results_due.push_back(mk_rsp(KIND_TX, POLL_BYTE, '0, '0, 1'b1));
						end
					end else begin
						r1_seen = it.rx_byte;
						if (held_cmd == CMD_IF_COND || held_cmd == CMD_READ_OCR) begin
							// r7 / r3: four trailing bytes follow
							card_phase  = CARD_COLLECT;
							trailer     = '0;
							trailer_cnt = '0;
							card_results_due.push_back(mk_rsp(KIND_TX, POLL_BYTE, '0, '0, 1'b1));
						end else begin
							card_phase = CARD_IDLE;
							card_results_due.push_back(mk_rsp(KIND_DONE, '0, r1_seen, '0, 1'b1));
						end
					end
				end else if (card_phase == CARD_COLLECT) begin
					took_effect = 1'b1;
					pushed      = 1;
					trailer     = {trailer[23:0], it.rx_byte};
					trailer_cnt = trailer_cnt + 3'd1;
					if (trailer_cnt >= 3'd4) begin
						card_phase = CARD_IDLE;
						card_results_due.push_back(mk_rsp(KIND_DONE, '0, r1_seen, trailer, 1'b1));
					end else begin
						card_results_due.push_back(mk_rsp(KIND_TX, POLL_BYTE, '0, '0, 1'b1));
					end
				end
			end
			default: begin
				// unused op code: nothing happens
			end
		endcase
	endtask

	// sender idles in bands: two noisy stretches, then one with no gaps
	function automatic int sender_gap();
		return ((useful_items / 50) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// offer one transfer, hold it until accepted, then predict its results
	task automatic offer(input req_item_t it, input int gap, output int pushed);
		bit took;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		compute_card_results(it, pushed, took);
		if (took) begin
			useful_items++;
		end
	endtask

	task automatic offer_one(input req_item_t it);
		int pushed;
		offer(it, sender_gap(), pushed);
	endtask

	// sender pause: nothing offered until every owed result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (card_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one card dialog with random content; most run to completion, some break off
	task automatic run_card_dialog();
		req_item_t it;
		int        pick;
		int        busy_bytes;
		pick = $urandom_range(0, 9);
		if (pick >= 8) begin
			// noise: raw random transfers of any op
			repeat ($urandom_range(1, 4)) offer_one(rand_req());
			return;
		end
		it = rand_req();
		it.op = OP_START;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			it.cmd_index = CMD_IF_COND;
		end else if (pick < 6) begin
			it.cmd_index = CMD_READ_OCR;
		end
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			it.timeout_ms = 16'($urandom_range(0, 4));
		end else if (pick < 8) begin
			it.timeout_ms = '0;
		end
		offer_one(it);
		// busy bytes, with ticks mixed in so that timeouts get reached
		busy_bytes = $urandom_range(0, 4);
		for (int i = 0; i < busy_bytes && card_phase == CARD_WAIT_R1; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					it = rand_req();
					it.op = OP_TICK;
					offer_one(it);
				end
			end
			it = rand_req();
			it.op = OP_RX;
			it.rx_byte[7] = 1'b1;
			offer_one(it);
		end
		// r1, unless the dialog breaks off here
		if (card_phase == CARD_WAIT_R1 && $urandom_range(0, 9) != 0) begin
			it = rand_req();
			it.op = OP_RX;
			it.rx_byte[7] = 1'b0;
			offer_one(it);
		end
		// trailing bytes of r3 / r7, a stray tick now and then
		while (card_phase == CARD_COLLECT && $urandom_range(0, 11) != 0) begin
			it = rand_req();
			it.op = ($urandom_range(0, 5) == 0) ? OP_TICK : OP_RX;
			offer_one(it);
		end
	endtask

	// compare one accepted result with the oldest one owed
	task automatic check_result(input rsp_item_t got);
		rsp_item_t want;
		rsp_seen++;
		if (card_results_due.size() == 0) begin
			failures++;
			if (failures <= MAX_REPORTS) begin
				$display("[%0t] unexpected result kind=%0d tx=%02h r1=%02h data=%08h last=%0d",
					$realtime, got.kind, got.tx_byte, got.r1, got.resp_data, got.last);
			end
			return;
		end
		want = card_results_due.pop_front();
		if (want.kind == KIND_DONE) begin
			r1_done++;
		end
		if (want.kind == KIND_TIMEOUT) begin
			timeouts++;
		end
		if (got.kind !== want.kind || got.tx_byte !== want.tx_byte || got.r1 !== want.r1 ||
				got.resp_data !== want.resp_data || got.last !== want.last) begin
			failures++;
			if (failures <= MAX_REPORTS) begin
				$display("[%0t] mismatch: expected kind=%0d tx=%02h r1=%02h data=%08h last=%0d",
					$realtime, want.kind, want.tx_byte, want.r1, want.resp_data, want.last);
				$display("[%0t]           actual   kind=%0d tx=%02h r1=%02h data=%08h last=%0d",
					$realtime, got.kind, got.tx_byte, got.r1, got.resp_data, got.last);
			end
		end
	endtask

	// receiver: check each transfer, then stall a random number of cycles
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			check_result(rsp);
			// every third band of results goes without stalls
			rsp_wait = ((rsp_seen / 120) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
		end
		if (hold_rsp) begin
			rsp_stall <= 1'b1;
		end else if (rsp_wait > 0) begin
			rsp_stall <= 1'b1;
			rsp_wait--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		while (rsp_seen < HOLD_AFTER) @(posedge clk);
		hold_rsp <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout with %0d results still owed", card_results_due.size());
		$display("Some tests failed");
		$finish;
	end

	// main stimulus
	initial begin
		drill_row_t drill[$];
		rsp_item_t  poll;
		rsp_item_t  gave_up;
		int         pushed;
		int         next_drain;

		poll    = mk_rsp(KIND_TX, POLL_BYTE, '0, '0, 1'b1);
		gave_up = mk_rsp(KIND_TIMEOUT, '0, '0, '0, 1'b1);

		// directed table
		// nothing to do right after reset: receive, tick and unused op are ignored
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h00), 1'b0, '0});
		drill.push_back('{mk_req(OP_TICK, '0, '0, 1'b0, '0, 8'h00), 1'b0, '0});
		drill.push_back('{mk_req(OP_UNUSED, 6'h3f, '1, 1'b1, '1, 8'hff), 1'b0, '0});
		// cmd0 with crc, busy, two ticks, busy again hits the timeout
		drill.push_back('{mk_req(OP_START, 6'd0, '0, 1'b1, 16'd2, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'hff), 1'b1, poll});
		drill.push_back('{mk_req(OP_TICK, '0, '0, 1'b0, '0, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_TICK, '0, '0, 1'b0, '0, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'hff), 1'b1, gave_up});
		// if-cond with r7 trailer, a tick during collection is ignored
		drill.push_back('{mk_req(OP_START, CMD_IF_COND, 32'h0000_01aa, 1'b1, '1, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h01), 1'b1, poll});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h00), 1'b1, poll});
		drill.push_back('{mk_req(OP_TICK, '0, '0, 1'b0, '0, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h00), 1'b1, poll});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h01), 1'b1, poll});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'haa), 1'b1,
			mk_rsp(KIND_DONE, '0, 8'h01, 32'h0000_01aa, 1'b1)});
		// zero timeout without crc: first busy byte already times out
		drill.push_back('{mk_req(OP_START, CMD_READ_OCR, '1, 1'b0, '0, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h80), 1'b1, gave_up});
		// largest fields, then a restart while busy, then a plain r1
		drill.push_back('{mk_req(OP_START, 6'h3f, '1, 1'b1, '1, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_START, 6'd17, 32'h1234_5678, 1'b1, 16'd5, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h7f), 1'b1,
			mk_rsp(KIND_DONE, '0, 8'h7f, '0, 1'b1)});
		// read-ocr with busy-looking trailing bytes, first byte lands on top
		drill.push_back('{mk_req(OP_START, CMD_READ_OCR, '0, 1'b1, 16'd1, '0), 1'b0, '0});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h00), 1'b1, poll});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'hff), 1'b1, poll});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h80), 1'b1, poll});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h00), 1'b1, poll});
		drill.push_back('{mk_req(OP_RX, '0, '0, 1'b0, '0, 8'h55), 1'b1,
			mk_rsp(KIND_DONE, '0, 8'h00, 32'hff80_0055, 1'b1)});

		// single reset at the start
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (drill[i]) begin
			offer(drill[i].item, sender_gap(), pushed);
			// obvious rows replace the predicted result by the typed one
			if (drill[i].typed && pushed == 1) begin
				card_results_due[card_results_due.size() - 1] = drill[i].want;
			end
		end
		drain_results();

		// random dialogs, with a full drain now and then
		next_drain = useful_items + DRAIN_EVERY;
		while (useful_items < RANDOM_ITEMS) begin
			run_card_dialog();
			if (useful_items >= next_drain) begin
				drain_results();
				next_drain = useful_items + DRAIN_EVERY;
			end
		end

		// end of stimulus: wait for all owed results, then a little longer
		req_valid <= 1'b0;
		while (card_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);

		$display("covered %0d command frames, %0d completed responses, %0d timeouts",
			frames_sent, r1_done, timeouts);
		$display("%0d effective transfers in, %0d results checked, %0d failures",
			useful_items, rsp_seen, failures);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
